// ===== rtl/csvfs_pkg.sv =====
`default_nettype none

package csvfs_pkg;

    localparam logic [7:0] QUOTE_BYTE    = 8'h22;
    localparam logic [7:0] DELIM_RESET   = 8'd44;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_FIELD    = 2'd1;
    localparam logic [1:0] KIND_REC_END  = 2'd2;

    localparam logic REG_DELIMITER  = 1'b0;
    localparam logic REG_DROP_EMPTY = 1'b1;

    // work left by one input item: an optional first result and an optional record end
    typedef struct packed {
        logic        r0_valid;
        logic        r0_is_data;
        logic [7:0]  r0_byte;
        logic        r1_valid;
        logic        r1_keep;
        logic [15:0] count;
    } csvfs_entry_t;

endpackage

`default_nettype wire

// ===== rtl/csvfs_front.sv =====
`default_nettype none

module csvfs_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 has_byte,
    input  wire logic                 end_of_record,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_wdata,
    output csvfs_pkg::csvfs_entry_t   entry,
    output logic                      entry_valid
);

    typedef enum logic [1:0] {
        MODE_OUT,
        MODE_IN,
        MODE_QSEEN
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        nonempty_reg, nonempty_next;
    logic [15:0] fields_reg, fields_next;
    logic [7:0]  delim_reg, delim_next;
    logic        drop_reg, drop_next;

    logic        is_quote;
    logic        is_delim;
    logic        outside;
    logic        keep_mid;
    logic        keep_end;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign is_quote = (in_byte == csvfs_pkg::QUOTE_BYTE);
    assign is_delim = (in_byte == delim_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        nonempty_next = nonempty_reg;
        fields_next   = fields_reg;
        outside       = 1'b0;
        keep_mid      = 1'b0;
        keep_end      = 1'b0;
        entry         = '0;

        if (has_byte)
        begin
            case (mode_reg)
                MODE_IN:
                begin
                    if (is_quote)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                    else
                    begin
                        nonempty_next    = 1'b1;
                        entry.r0_valid   = 1'b1;
                        entry.r0_is_data = 1'b1;
                        entry.r0_byte    = in_byte;
                    end
                end
                MODE_QSEEN:
                begin
                    if (is_quote)
                    begin
                        mode_next        = MODE_IN;
                        nonempty_next    = 1'b1;
                        entry.r0_valid   = 1'b1;
                        entry.r0_is_data = 1'b1;
                        entry.r0_byte    = in_byte;
                    end
                    else
                    begin
                        outside = 1'b1;
                    end
                end
                default:
                begin
                    outside = 1'b1;
                end
            endcase

            if (outside)
            begin
                mode_next = MODE_OUT;
                if (is_quote)
                begin
                    mode_next = MODE_IN;
                end
                else if (is_delim)
                begin
                    keep_mid = nonempty_next || !drop_reg;
                    if (keep_mid)
                    begin
                        entry.r0_valid = 1'b1;
                        fields_next    = sat_inc(fields_next);
                    end
                    nonempty_next = 1'b0;
                end
                else
                begin
                    nonempty_next    = 1'b1;
                    entry.r0_valid   = 1'b1;
                    entry.r0_is_data = 1'b1;
                    entry.r0_byte    = in_byte;
                end
            end
        end

        if (end_of_record)
        begin
            keep_end       = nonempty_next || !drop_reg;
            entry.r1_valid = 1'b1;
            entry.r1_keep  = keep_end;
            entry.count    = keep_end ? sat_inc(fields_next) : fields_next;
            mode_next      = MODE_OUT;
            nonempty_next  = 1'b0;
            fields_next    = 16'd0;
        end
    end

    assign entry_valid = accept && (entry.r0_valid || entry.r1_valid);

    always_comb
    begin
        delim_next = delim_reg;
        drop_next  = drop_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                csvfs_pkg::REG_DELIMITER:  delim_next = cfg_wdata;
                csvfs_pkg::REG_DROP_EMPTY: drop_next  = cfg_wdata[0];
                default:                   delim_next = delim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OUT;
            nonempty_reg <= 1'b0;
            fields_reg   <= 16'd0;
            delim_reg    <= csvfs_pkg::DELIM_RESET;
            drop_reg     <= 1'b0;
        end
        else
        begin
            delim_reg <= delim_next;
            drop_reg  <= drop_next;
            if (accept)
            begin
                mode_reg     <= mode_next;
                nonempty_reg <= nonempty_next;
                fields_reg   <= fields_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csvfs_queue.sv =====
`default_nettype none

module csvfs_queue #(
    parameter int DEPTH = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  csvfs_pkg::csvfs_entry_t       wr_data,
    input  wire logic                     rd_en,
    output csvfs_pkg::csvfs_entry_t       rd_data,
    output logic                          q_full,
    output logic                          q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    csvfs_pkg::csvfs_entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csvfs_back.sv =====
`default_nettype none

module csvfs_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  csvfs_pkg::csvfs_entry_t   q_data,
    input  wire logic                 q_empty,
    output logic                      q_rd,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [1:0]                kind,
    output logic [7:0]                out_byte,
    output logic                      last,
    output logic [15:0]               field_count
);

    csvfs_pkg::csvfs_entry_t ent_reg, ent_next;
    logic                    valid_reg, valid_next;
    logic                    phase_reg, phase_next;

    logic show_r0;
    logic consume;
    logic done;
    logic load;

    assign show_r0 = !phase_reg && ent_reg.r0_valid;
    assign consume = pop && valid_reg;
    assign done    = consume && !(show_r0 && ent_reg.r1_valid);
    assign load    = !valid_reg || done;
    assign q_rd    = load && !q_empty;

    assign empty       = !valid_reg;
    assign last        = !show_r0;
    assign field_count = show_r0 ? 16'd0 : ent_reg.count;
    assign out_byte    = (show_r0 && ent_reg.r0_is_data) ? ent_reg.r0_byte : 8'd0;

    always_comb
    begin
        if (show_r0)
        begin
            kind = ent_reg.r0_is_data ? csvfs_pkg::KIND_DATA : csvfs_pkg::KIND_FIELD;
        end
        else
        begin
            kind = ent_reg.r1_keep ? csvfs_pkg::KIND_FIELD : csvfs_pkg::KIND_REC_END;
        end
    end

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            ent_next   = q_data;
            valid_next = !q_empty;
            phase_next = 1'b0;
        end
        else if (consume)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csv_field_splitter.sv =====
// CSV field splitter.
// Input queue side: push/full with in_byte, has_byte, end_of_record. One item per
// byte; end_of_record closes the record, has_byte 0 with it is a bare record end.
// Result queue side: empty/pop with kind, out_byte, last, field_count. Results are
// unescaped data bytes, field ends, and on the record's final result last = 1 with
// the kept-field count (saturating at 65535).
// Config: cfg_we/cfg_index/cfg_wdata; index 0 delimiter (reset 44), index 1
// drop_empty (reset 0). Write only while the block is idle.
// Throughput: one item accepted per cycle while full is low. Results leave one
// per cycle while pop is high; an item with a byte and a record end can give
// two results, so the result port sets the rate for such items.
// Path: an item that yields a result is written to the item queue (QUEUE_DEPTH
// entries) when it is accepted and moves into the output register once that
// register is empty or its last result is popped.
// Stall: while pop is low the output holds; the queue fills and full rises,
// after which push is ignored. Reset empties the queue, clears the output and
// the parse state, and restores the register defaults.
`default_nettype none

module csv_field_splitter #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_record,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic [15:0]      field_count,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    csvfs_pkg::csvfs_entry_t front_entry;
    csvfs_pkg::csvfs_entry_t q_data;
    logic                    front_valid;
    logic                    accept;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_rd;

    assign full   = q_full;
    assign accept = push && !q_full;

    csvfs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_record (end_of_record),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .entry         (front_entry),
        .entry_valid   (front_valid)
    );

    csvfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_entry),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    csvfs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .out_byte    (out_byte),
        .last        (last),
        .field_count (field_count)
    );

endmodule

`default_nettype wire

// ===== rtl/csvfs_checker.sv =====
`default_nettype none

module csvfs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  out_byte,
    input wire logic        last,
    input wire logic [15:0] field_count
);

    // count only rides on the final result of a record
    a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (field_count == 16'd0))
        else $error("field_count set on a non-final result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind == csvfs_pkg::KIND_DATA || kind == csvfs_pkg::KIND_FIELD
                    || kind == csvfs_pkg::KIND_REC_END))
        else $error("illegal kind");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != csvfs_pkg::KIND_DATA) |-> (out_byte == 8'd0))
        else $error("out_byte set on a marker");

    a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (kind != csvfs_pkg::KIND_DATA))
        else $error("last on a data byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(out_byte)
                              && $stable(last) && $stable(field_count)))
        else $error("result changed while stalled");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .out_byte    (out_byte),
    .last        (last),
    .field_count (field_count)
);

`default_nettype wire

// ===== dv/csv_split_checker.sv =====
`timescale 1ns / 100ps

module csv_split_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_record,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  out_byte,
    input  wire logic        last,
    input  wire logic [15:0] field_count,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    output int               mismatches,
    output int               pending,
    output int               results_checked
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        last;
        logic [15:0] field_count;
    } split_token_t;

    typedef enum logic [1:0] {
        QM_OUTSIDE    = 2'd0,
        QM_QUOTED     = 2'd1,
        QM_QUOTE_SEEN = 2'd2
    } quote_state_t;

    split_token_t tokens_due[$];

    logic [7:0]   delim_copy;
    logic         drop_copy;
    quote_state_t qstate;
    logic         field_has_byte;
    logic [15:0]  kept_fields;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic emit(input logic [1:0] k, input logic [7:0] b, input logic l,
                        input logic [15:0] cnt);
        split_token_t t;
        t.kind        = k;
        t.out_byte    = b;
        t.last        = l;
        t.field_count = cnt;
        tokens_due.push_back(t);
    endtask

    task automatic close_field(output logic keep);
        keep = field_has_byte || !drop_copy;
        if (keep && kept_fields != 16'hFFFF)
            kept_fields = kept_fields + 16'd1;
        field_has_byte = 1'b0;
    endtask

    task automatic split_byte(input logic [7:0] b, input logic has, input logic eor);
        logic outside;
        logic keep;
        if (has)
        begin
            if (qstate == QM_QUOTED)
            begin
                if (b == csvfs_pkg::QUOTE_BYTE)
                    qstate = QM_QUOTE_SEEN;
                else
                begin
                    field_has_byte = 1'b1;
                    emit(csvfs_pkg::KIND_DATA, b, 1'b0, 16'd0);
                end
            end
            else
            begin
                outside = 1'b1;
                if (qstate == QM_QUOTE_SEEN && b == csvfs_pkg::QUOTE_BYTE)
                begin
                    qstate         = QM_QUOTED;
                    field_has_byte = 1'b1;
                    emit(csvfs_pkg::KIND_DATA, b, 1'b0, 16'd0);
                    outside        = 1'b0;
                end
                if (outside)
                begin
                    qstate = QM_OUTSIDE;
                    if (b == csvfs_pkg::QUOTE_BYTE)
                        qstate = QM_QUOTED;
                    else if (b == delim_copy)
                    begin
                        close_field(keep);
                        if (keep)
                            emit(csvfs_pkg::KIND_FIELD, 8'd0, 1'b0, 16'd0);
                    end
                    else
                    begin
                        field_has_byte = 1'b1;
                        emit(csvfs_pkg::KIND_DATA, b, 1'b0, 16'd0);
                    end
                end
            end
        end
        if (eor)
        begin
            close_field(keep);
            emit(keep ? csvfs_pkg::KIND_FIELD : csvfs_pkg::KIND_REC_END, 8'd0, 1'b1,
                 kept_fields);
            qstate         = QM_OUTSIDE;
            field_has_byte = 1'b0;
            kept_fields    = 16'd0;
        end
    endtask

    task automatic check_result();
        split_token_t want;
        results_checked++;
        if (tokens_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h", kind, out_byte));
            return;
        end
        want = tokens_due.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
        if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        if (field_count !== want.field_count)
            report_mismatch($sformatf("field_count %0d, want %0d",
                                      field_count, want.field_count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_copy      = csvfs_pkg::DELIM_RESET;
            drop_copy       = 1'b0;
            qstate          = QM_OUTSIDE;
            field_has_byte  = 1'b0;
            kept_fields     = 16'd0;
            mismatches      = 0;
            results_checked = 0;
            tokens_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == csvfs_pkg::REG_DELIMITER)
                    delim_copy = cfg_wdata;
                else
                    drop_copy = cfg_wdata[0];
            end
            if (pop && !empty)
                check_result();
            if (push && !full)
                split_byte(in_byte, has_byte, end_of_record);
        end
        pending = tokens_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 12;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        has_byte;
    logic        end_of_record;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [15:0] field_count;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;

    int mismatches;
    int pending;
    int results_checked;

    int   items_sent   = 0;
    int   records_sent = 0;
    int   settings_run = 1;
    int   holds_done   = 0;
    int   send_burst   = 0;
    logic random_phase = 1'b0;
    logic [7:0] cur_delim = csvfs_pkg::DELIM_RESET;

    logic [7:0] phase_delim [6] = '{8'd44, 8'd0, 8'd255, 8'h22, 8'd9, 8'd44};
    logic       phase_drop  [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    csv_field_splitter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .has_byte      (has_byte),
        .end_of_record (end_of_record),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .out_byte      (out_byte),
        .last          (last),
        .field_count   (field_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    csv_split_checker split_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .has_byte        (has_byte),
        .end_of_record   (end_of_record),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .out_byte        (out_byte),
        .last            (last),
        .field_count     (field_count),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_delim || b == csvfs_pkg::QUOTE_BYTE);
        return b;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic has, input logic eor);
        int gap;
        gap = 0;
        if (send_burst > 0)
            send_burst--;
        else
        begin
            gap = idle_length();
            if ($urandom_range(0, 24) == 0)
                send_burst = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push          <= 1'b1;
        in_byte       <= b;
        has_byte      <= has;
        end_of_record <= eor;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        if (has || eor)
            items_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_registers(input logic [7:0] delim, input logic drop);
        push <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= csvfs_pkg::REG_DELIMITER;
        cfg_wdata <= delim;
        @(negedge clk);
        cfg_index <= csvfs_pkg::REG_DROP_EMPTY;
        cfg_wdata <= {7'd0, drop};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_delim = delim;
        settings_run++;
    endtask

    task automatic send_random_record();
        logic [7:0] rec[$];
        logic [7:0] b;
        logic       bare_end;
        int         nfields;
        int         len;
        int         style;
        int         i;
        nfields = $urandom_range(1, 6);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                rec.push_back(cur_delim);
            style = $urandom_range(0, 9);
            len   = $urandom_range(0, 5);
            if (style < 5)
            begin
                repeat (len) rec.push_back(plain_byte());
            end
            else
            begin
                rec.push_back(csvfs_pkg::QUOTE_BYTE);
                repeat (len)
                begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 4) == 0)
                        b = csvfs_pkg::QUOTE_BYTE;
                    else if ($urandom_range(0, 5) == 0)
                        b = cur_delim;
                    rec.push_back(b);
                    if (b == csvfs_pkg::QUOTE_BYTE)
                        rec.push_back(b);
                end
                // unterminated quote only on the final field
                if (!(style == 9 && f == nfields - 1))
                    rec.push_back(csvfs_pkg::QUOTE_BYTE);
                if (style == 8)
                    repeat ($urandom_range(1, 2)) rec.push_back(plain_byte());
            end
        end
        bare_end = (rec.size() == 0) || ($urandom_range(0, 2) == 0);
        for (i = 0; i < rec.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(rec[i], 1'b1, !bare_end && (i == rec.size() - 1));
        end
        if (bare_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        records_sent++;
    endtask

    task automatic send_noise_record();
        logic [7:0] b;
        int         r;
        repeat ($urandom_range(0, 8))
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                b = csvfs_pkg::QUOTE_BYTE;
            else if (r == 1)
                b = cur_delim;
            else
                b = 8'($urandom_range(0, 255));
            send_item(b, $urandom_range(0, 4) != 0, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        records_sent++;
    endtask

    // result side: random stalls, quiet stretches, and long hold-offs to fill the block
    initial
    begin : result_side
        int stall_left;
        int quiet_left;
        int r;
        stall_left = 0;
        quiet_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (random_phase && (holds_done == 0 || (holds_done == 1 && items_sent >= 450)))
                begin
                    holds_done++;
                    stall_left = 120;
                end
                else if (quiet_left > 0)
                    quiet_left--;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        quiet_left = $urandom_range(20, 60);
                    else
                        stall_left = idle_length();
                end
            end
        end
    end

    initial
    begin : stimulus
        int target;
        rst_n         = 1'b0;
        push          = 1'b0;
        in_byte       = 8'd0;
        has_byte      = 1'b0;
        end_of_record = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = csvfs_pkg::REG_DELIMITER;
        cfg_wdata     = 8'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: comma, empty fields kept
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h2C, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h41, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h42, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h43, 1'b1, 1'b0);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b0);
        send_item(8'h44, 1'b0, 1'b0);
        send_item(8'h2C, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(csvfs_pkg::QUOTE_BYTE, 1'b1, 1'b1);
        records_sent += 3;

        // zero byte as delimiter, empty fields dropped
        set_registers(8'h00, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        records_sent += 2;

        for (int p = 0; p < 7; p++)
        begin
            if (p < 6)
                set_registers(phase_delim[p], phase_drop[p]);
            else
                set_registers(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            random_phase = 1'b1;
            target = items_sent + 100;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_random_record();
                else
                    send_noise_record();
            end
        end
        random_phase = 1'b0;

        push <= 1'b0;
        wait_drained();
        $display("Covered %0d records, %0d items, %0d register settings, %0d long hold-offs;",
                 records_sent, items_sent, settings_run, holds_done);
        $display("%0d results checked.", results_checked);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csvfs_pkg.sv
rtl/csvfs_front.sv
rtl/csvfs_queue.sv
rtl/csvfs_back.sv
rtl/csv_field_splitter.sv
rtl/csvfs_checker.sv
dv/csv_split_checker.sv
dv/testbench.sv
